[rtl/pgr_pkg.sv]
// ----------------------------------------------------------------------------
// pgr_pkg: pan gesture recognizer shared types and constants
// Phase, event and control-state codes, register indexes, fixed field widths.
// ----------------------------------------------------------------------------
package pgr_pkg;

	typedef enum logic [2:0] {
		PH_UNSURE      = 3'd0,
		PH_START       = 3'd1,
		PH_STAY        = 3'd2,
		PH_END         = 3'd3,
		PH_FAILED      = 3'd4,
		PH_INTERRUPTED = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		K_START = 2'd0,
		K_STAY  = 2'd1,
		K_END   = 2'd2,
		K_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_DIVGO,
		S_DIVWAIT,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic in_ready;
		logic div_go;
		logic div_fin;
		logic out_load;
	} ctl_out_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL     = 3'd4;

	localparam logic [1:0] AXIS_ANY  = 2'd0;
	localparam logic [1:0] AXIS_HORZ = 2'd1;
	localparam logic [1:0] AXIS_VERT = 2'd2;

	localparam int THR_W     = 8;
	localparam int RATE_W    = 8;
	localparam int DECEL_W   = 16;
	localparam int TIME_W    = 22;
	localparam int DIST_W    = 24;
	localparam int FRAC_BITS = 16;

	localparam logic [THR_W-1:0]   RST_THRESHOLD = 8'd10;
	localparam logic [RATE_W-1:0]  RST_RATE      = 8'd60;
	localparam logic [DECEL_W-1:0] RST_DECEL     = 16'd5000;

endpackage

[rtl/pgr_serial_div.sv]
// ----------------------------------------------------------------------------
// pgr_serial_div: bit-serial restoring divider with saturation
// One quotient bit per cycle; a quotient that overflows Q_W bits gives all ones.
// ----------------------------------------------------------------------------
module pgr_serial_div #(
	parameter int NUM_W = 36,
	parameter int DEN_W = 18,
	parameter int Q_W   = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [Q_W-1:0]   quo
);

	localparam int HW   = NUM_W - Q_W;
	localparam int XW   = ((HW > DEN_W) ? HW : DEN_W) + 1;
	localparam int CNTW = $clog2(Q_W + 1);

	logic [XW-1:0]    hi_ext;
	logic [XW-1:0]    den_ext;
	logic             ovf;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   sh_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign hi_ext  = XW'(num[NUM_W-1:Q_W]);
	assign den_ext = XW'(den);
	assign ovf     = hi_ext >= den_ext;

	assign trial = {rem_q, sh_q[Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !ovf;
			cnt_q  <= CNTW'(Q_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= DEN_W'(hi_ext);
			sh_q  <= ovf ? '1 : num[Q_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			sh_q  <= {sh_q[Q_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = sh_q;

endmodule

[rtl/pan_gesture_recognizer_unit.sv]
// ----------------------------------------------------------------------------
// pan_gesture_recognizer_unit: pan gesture recognizer
// Tracks one touch gesture across requests and computes fling time and distance
// at the end of a pan.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_ready  | kind, touch_x, touch_y
//   out     | out_valid/out_ready| gesture_state, notify, pos, move, origin,
//           |                    | fling_time, fling_dist
//   cfg     | cfg_we             | cfg_index, cfg_data
//
// A request without a fling goes through the done state into the output register.
// A request that ends a pan passes the multiply states S_MUL1 and S_MUL2, then four
// bit-serial dividers in parallel, one quotient bit per cycle (22-bit time, 23-bit distance).
// A new request is taken while the previous result waits in the output register.
// Reset restores the register defaults and clears all gesture state.
// ----------------------------------------------------------------------------
module pan_gesture_recognizer_unit
	import pgr_pkg::*;
#(
	parameter int HISTORY_DEPTH = 3,
	parameter int COORD_BITS    = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   kind,
	input  logic [COORD_BITS-1:0]        touch_x,
	input  logic [COORD_BITS-1:0]        touch_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   gesture_state,
	output logic                         notify,
	output logic [COORD_BITS-1:0]        pos_x,
	output logic [COORD_BITS-1:0]        pos_y,
	output logic signed [COORD_BITS:0]   move_dx,
	output logic signed [COORD_BITS:0]   move_dy,
	output logic [COORD_BITS-1:0]        origin_x,
	output logic [COORD_BITS-1:0]        origin_y,
	output logic [TIME_W-1:0]            fling_time_x,
	output logic [TIME_W-1:0]            fling_time_y,
	output logic signed [DIST_W-1:0]     fling_dist_x,
	output logic signed [DIST_W-1:0]     fling_dist_y,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int CB   = COORD_BITS;
	localparam int HD   = HISTORY_DEPTH;
	localparam int CW   = $clog2(HD + 1);
	localparam int IW   = $clog2(HD);
	localparam int CSW  = 2 * CW;
	localparam int MRW  = CB + RATE_W;
	localparam int SQW  = 2 * MRW;
	localparam int TNW  = MRW + FRAC_BITS;
	localparam int DTW  = CW + DECEL_W;
	localparam int DDW  = CSW + DECEL_W + 1;
	localparam int DQW  = DIST_W - 1;

	// configuration
	logic               enable_q;
	logic [1:0]         axis_q;
	logic [THR_W-1:0]   thr_q;
	logic [RATE_W-1:0]  rate_q;
	logic [DECEL_W-1:0] dec_q;

	// gesture state
	phase_t                 phase_q;
	logic [CB-1:0]          begin_x_q, begin_y_q;
	logic [CB-1:0]          last_x_q, last_y_q;
	logic signed [CB:0]     delta_x_q, delta_y_q;
	logic [CB-1:0]          hist_x_q [HD];
	logic [CB-1:0]          hist_y_q [HD];
	logic [CW-1:0]          hcnt_q;
	logic [TIME_W-1:0]      ftime_x_q, ftime_y_q;
	logic signed [DIST_W-1:0] fdist_x_q, fdist_y_q;

	// fling datapath
	logic signed [CB:0] fdx_q, fdy_q;
	logic [CW-1:0]      c_q;
	logic [CSW-1:0]     csq_q;
	logic [MRW-1:0]     mrx_q, mry_q;
	logic [SQW-1:0]     sqx_q, sqy_q;
	logic [DTW-1:0]     dent_q;
	logic [DDW-1:0]     dend_q;
	logic               zx_q, zy_q, sx_q, sy_q;

	// request result
	phase_t st_q;
	logic   note_q;

	// output register
	logic                     out_valid_q;
	phase_t                   res_st_q;
	logic                     res_note_q;
	logic [CB-1:0]            res_px_q, res_py_q;
	logic signed [CB:0]       res_dx_q, res_dy_q;
	logic [CB-1:0]            res_ox_q, res_oy_q;
	logic [TIME_W-1:0]        res_tx_q, res_ty_q;
	logic signed [DIST_W-1:0] res_sx_q, res_sy_q;

	ctl_state_t state_q, state_nx;
	ctl_out_t   ctl;

	kind_t              ev;
	logic               refused;
	logic               is_move;
	logic signed [CB:0] dlx, dly, odx, ody;
	logic [CB-1:0]      ax, ay, ox, oy, thr_ext;
	logic               moved, axis_ok;
	phase_t             ph_nx, st_nx;
	logic               note_nx, do_fling;
	logic [CB-1:0]      push_x, push_y;
	logic [CW-1:0]      cm1;
	logic signed [CB:0] hdx, hdy;
	logic [CB-1:0]      mx, my;
	logic               any_busy;
	logic               busy_tx, busy_ty, busy_dx, busy_dy;
	logic [TIME_W-1:0]  q_tx, q_ty;
	logic [DQW-1:0]     q_dx, q_dy;
	logic signed [DIST_W-1:0] dist_x, dist_y;
	logic               accept;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			axis_q   <= AXIS_ANY;
			thr_q    <= RST_THRESHOLD;
			rate_q   <= RST_RATE;
			dec_q    <= RST_DECEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:    enable_q <= cfg_data[0];
				REG_AXIS_MODE: axis_q   <= cfg_data[1:0];
				REG_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				REG_RATE:      rate_q   <= cfg_data[RATE_W-1:0];
				REG_DECEL:     dec_q    <= cfg_data[DECEL_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------- event decision
	always_comb begin
		ev      = kind_t'(kind);
		refused = !enable_q ||
			(ev != K_START && (phase_q == PH_FAILED || phase_q == PH_INTERRUPTED));
		is_move = (ev == K_STAY) || (ev == K_END);

		dlx = $signed({1'b0, touch_x}) - $signed({1'b0, last_x_q});
		dly = $signed({1'b0, touch_y}) - $signed({1'b0, last_y_q});
		odx = $signed({1'b0, begin_x_q}) - $signed({1'b0, touch_x});
		ody = $signed({1'b0, begin_y_q}) - $signed({1'b0, touch_y});
		ax  = dlx[CB] ? CB'(-dlx) : CB'(dlx);
		ay  = dly[CB] ? CB'(-dly) : CB'(dly);
		ox  = odx[CB] ? CB'(-odx) : CB'(odx);
		oy  = ody[CB] ? CB'(-ody) : CB'(ody);
		thr_ext = CB'(thr_q);
		moved   = (ox > thr_ext) || (oy > thr_ext);

		unique case (axis_q)
			AXIS_ANY:  axis_ok = 1'b1;
			AXIS_HORZ: axis_ok = ax > ay;
			AXIS_VERT: axis_ok = ax < ay;
			default:   axis_ok = 1'b0;
		endcase

		ph_nx = phase_q;
		if (!refused) begin
			unique case (ev)
				K_START: ph_nx = PH_UNSURE;
				K_NONE:  ph_nx = PH_FAILED;
				default: begin
					if (phase_q == PH_UNSURE) begin
						ph_nx = (moved && axis_ok) ? PH_START : PH_UNSURE;
					end else begin
						ph_nx = (ev == K_STAY) ? PH_STAY : PH_END;
					end
				end
			endcase
		end

		st_nx    = enable_q ? ph_nx : PH_FAILED;
		note_nx  = !refused && is_move &&
			(ph_nx == PH_START || ph_nx == PH_STAY || ph_nx == PH_END);
		do_fling = !refused && is_move && (ph_nx == PH_END);

		push_x = (ev == K_NONE) ? last_x_q : touch_x;
		push_y = (ev == K_NONE) ? last_y_q : touch_y;

		cm1 = hcnt_q - CW'(1);
		if (hcnt_q != '0) begin
			hdx = $signed({1'b0, hist_x_q[cm1[IW-1:0]]}) - $signed({1'b0, hist_x_q[0]});
			hdy = $signed({1'b0, hist_y_q[cm1[IW-1:0]]}) - $signed({1'b0, hist_y_q[0]});
		end else begin
			hdx = '0;
			hdy = '0;
		end
	end

	assign accept = in_valid && ctl.in_ready;

	// -------------------------------------------------------- gesture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_UNSURE;
			begin_x_q <= '0;
			begin_y_q <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			delta_x_q <= '0;
			delta_y_q <= '0;
			hcnt_q    <= '0;
			for (int i = 0; i < HD; i++) begin
				hist_x_q[i] <= '0;
				hist_y_q[i] <= '0;
			end
		end else if (accept && !refused) begin
			phase_q <= ph_nx;
			if (ev == K_START) begin
				begin_x_q <= touch_x;
				begin_y_q <= touch_y;
			end
			if (ev != K_NONE) begin
				last_x_q <= touch_x;
				last_y_q <= touch_y;
			end
			if (is_move) begin
				delta_x_q <= dlx;
				delta_y_q <= dly;
			end
			for (int i = HD - 1; i > 0; i--) begin
				hist_x_q[i] <= hist_x_q[i-1];
				hist_y_q[i] <= hist_y_q[i-1];
			end
			hist_x_q[0] <= push_x;
			hist_y_q[0] <= push_y;
			if (ev == K_START) begin
				hcnt_q <= CW'(1);
			end else if (hcnt_q < CW'(HD)) begin
				hcnt_q <= hcnt_q + CW'(1);
			end
		end
	end

	// -------------------------------------------------------- fling datapath
	assign mx = fdx_q[CB] ? CB'(-fdx_q) : CB'(fdx_q);
	assign my = fdy_q[CB] ? CB'(-fdy_q) : CB'(fdy_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			st_q   <= st_nx;
			note_q <= note_nx;
			fdx_q  <= hdx;
			fdy_q  <= hdy;
			c_q    <= hcnt_q;
			csq_q  <= CSW'(hcnt_q) * CSW'(hcnt_q);
		end
		if (state_q == S_MUL1) begin
			mrx_q  <= MRW'(mx) * MRW'(rate_q);
			mry_q  <= MRW'(my) * MRW'(rate_q);
			dent_q <= DTW'(c_q) * DTW'(dec_q);
			dend_q <= {(DDW-1)'(csq_q) * (DDW-1)'(dec_q), 1'b0};
			zx_q   <= (mx == '0) || (rate_q == '0) || (c_q == '0);
			zy_q   <= (my == '0) || (rate_q == '0) || (c_q == '0);
			sx_q   <= fdx_q[CB];
			sy_q   <= fdy_q[CB];
		end
		if (state_q == S_MUL2) begin
			sqx_q <= SQW'(mrx_q) * SQW'(mrx_q);
			sqy_q <= SQW'(mry_q) * SQW'(mry_q);
		end
	end

	pgr_serial_div #(.NUM_W(TNW), .DEN_W(DTW), .Q_W(TIME_W)) u_div_tx (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_go),
		.num({mrx_q, {FRAC_BITS{1'b0}}}), .den(dent_q), .busy(busy_tx), .quo(q_tx)
	);

	pgr_serial_div #(.NUM_W(TNW), .DEN_W(DTW), .Q_W(TIME_W)) u_div_ty (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_go),
		.num({mry_q, {FRAC_BITS{1'b0}}}), .den(dent_q), .busy(busy_ty), .quo(q_ty)
	);

	pgr_serial_div #(.NUM_W(SQW), .DEN_W(DDW), .Q_W(DQW)) u_div_dx (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_go),
		.num(sqx_q), .den(dend_q), .busy(busy_dx), .quo(q_dx)
	);

	pgr_serial_div #(.NUM_W(SQW), .DEN_W(DDW), .Q_W(DQW)) u_div_dy (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_go),
		.num(sqy_q), .den(dend_q), .busy(busy_dy), .quo(q_dy)
	);

	assign any_busy = busy_tx || busy_ty || busy_dx || busy_dy;
	assign dist_x   = sx_q ? -$signed({1'b0, q_dx}) : $signed({1'b0, q_dx});
	assign dist_y   = sy_q ? -$signed({1'b0, q_dy}) : $signed({1'b0, q_dy});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ftime_x_q <= '0;
			ftime_y_q <= '0;
			fdist_x_q <= '0;
			fdist_y_q <= '0;
		end else if (ctl.div_fin) begin
			ftime_x_q <= zx_q ? '0 : q_tx;
			ftime_y_q <= zy_q ? '0 : q_ty;
			fdist_x_q <= zx_q ? '0 : dist_x;
			fdist_y_q <= zy_q ? '0 : dist_y;
		end
	end

	// --------------------------------------------------------------- control
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_nx = do_fling ? S_MUL1 : S_DONE;
			S_MUL1:    state_nx = S_MUL2;
			S_MUL2:    state_nx = S_DIVGO;
			S_DIVGO:   state_nx = S_DIVWAIT;
			S_DIVWAIT: if (!any_busy) state_nx = S_DONE;
			S_DONE:    if (!out_valid_q || out_ready) state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.in_ready = state_q == S_IDLE;
		ctl.div_go   = state_q == S_DIVGO;
		ctl.div_fin  = (state_q == S_DIVWAIT) && !any_busy;
		ctl.out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// -------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			res_st_q   <= st_q;
			res_note_q <= note_q;
			res_px_q   <= last_x_q;
			res_py_q   <= last_y_q;
			res_dx_q   <= delta_x_q;
			res_dy_q   <= delta_y_q;
			res_ox_q   <= begin_x_q;
			res_oy_q   <= begin_y_q;
			res_tx_q   <= ftime_x_q;
			res_ty_q   <= ftime_y_q;
			res_sx_q   <= fdist_x_q;
			res_sy_q   <= fdist_y_q;
		end
	end

	assign in_ready      = ctl.in_ready;
	assign out_valid     = out_valid_q;
	assign gesture_state = res_st_q;
	assign notify        = res_note_q;
	assign pos_x         = res_px_q;
	assign pos_y         = res_py_q;
	assign move_dx       = res_dx_q;
	assign move_dy       = res_dy_q;
	assign origin_x      = res_ox_q;
	assign origin_y      = res_oy_q;
	assign fling_time_x  = res_tx_q;
	assign fling_time_y  = res_ty_q;
	assign fling_dist_x  = res_sx_q;
	assign fling_dist_y  = res_sy_q;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: pan gesture recognizer testbench
// Drives touch requests through the valid/ready input with random gaps and
// stalls on the result side, and checks every result field against an
// in-bench model of the gesture phase, history and fling arithmetic. The run
// steps through several register settings, including zero rate and zero
// deceleration, saturating flings and the unused axis mode, and holds off the
// result side once long enough to back up the input.
// ----------------------------------------------------------------------------
module tb
	import pgr_pkg::*;
();

	localparam int CB          = 12;
	localparam int HIST        = 3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 40;
	localparam int LIMIT       = 500000;
	localparam int COORD_MAX   = (1 << CB) - 1;

	localparam logic [1:0] AXIS_UNUSED = 2'd3;
	localparam longint unsigned TIME_SAT = 64'd4194303;
	localparam longint unsigned DIST_SAT = 64'd8388607;

	typedef struct {
		phase_t                  state;
		logic                    notify;
		logic [CB-1:0]           pos_x;
		logic [CB-1:0]           pos_y;
		logic signed [CB:0]      move_dx;
		logic signed [CB:0]      move_dy;
		logic [CB-1:0]           origin_x;
		logic [CB-1:0]           origin_y;
		logic [TIME_W-1:0]       time_x;
		logic [TIME_W-1:0]       time_y;
		logic signed [DIST_W-1:0] dist_x;
		logic signed [DIST_W-1:0] dist_y;
	} gesture_result_t;

	class gesture_scoreboard;
		logic               en;
		logic [1:0]         axis;
		logic [THR_W-1:0]   thr;
		logic [RATE_W-1:0]  rate;
		logic [DECEL_W-1:0] decel;

		phase_t ph;
		int bx, by, lx, ly, dx, dy;
		int hx[HIST];
		int hy[HIST];
		int hcount;
		logic [TIME_W-1:0]        tmx, tmy;
		logic signed [DIST_W-1:0] dsx, dsy;

		gesture_result_t expected_q[$];
		int errors;

		function new();
			en = 1'b1;
			axis = AXIS_ANY;
			thr = RST_THRESHOLD;
			rate = RST_RATE;
			decel = RST_DECEL;
			ph = PH_UNSURE;
			bx = 0; by = 0; lx = 0; ly = 0; dx = 0; dy = 0;
			foreach (hx[i]) begin
				hx[i] = 0;
				hy[i] = 0;
			end
			hcount = 0;
			tmx = '0; tmy = '0; dsx = '0; dsy = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_ENABLE:    en = d[0];
				REG_AXIS_MODE: axis = d[1:0];
				REG_THRESHOLD: thr = d[THR_W-1:0];
				REG_RATE:      rate = d[RATE_W-1:0];
				REG_DECEL:     decel = d[DECEL_W-1:0];
				default: ;
			endcase
		endfunction

		function int mag(int v);
			return (v < 0) ? -v : v;
		endfunction

		function void fling(int d, int c, output logic [TIME_W-1:0] t,
				output logic signed [DIST_W-1:0] s);
			longint unsigned m, r, q, n, cc, dc;
			m = longint'(mag(d));
			r = rate;
			cc = longint'(c);
			dc = decel;
			if (m == 0 || r == 0 || cc == 0) begin
				t = '0;
				s = '0;
				return;
			end
			if (dc == 0) begin
				t = TIME_SAT[TIME_W-1:0];
				s = DIST_SAT[DIST_W-1:0];
				if (d < 0)
					s = -s;
				return;
			end
			q = (m * r * 64'd65536) / (cc * dc);
			t = (q > TIME_SAT) ? TIME_SAT[TIME_W-1:0] : q[TIME_W-1:0];
			n = (m * m * r * r) / (64'd2 * cc * cc * dc);
			if (n > DIST_SAT)
				n = DIST_SAT;
			s = n[DIST_W-1:0];
			if (d < 0)
				s = -s;
		endfunction

		function void emit(phase_t st, logic nt);
			gesture_result_t r;
			r.state = st;
			r.notify = nt;
			r.pos_x = lx[CB-1:0];
			r.pos_y = ly[CB-1:0];
			r.move_dx = dx[CB:0];
			r.move_dy = dy[CB:0];
			r.origin_x = bx[CB-1:0];
			r.origin_y = by[CB-1:0];
			r.time_x = tmx;
			r.time_y = tmy;
			r.dist_x = dsx;
			r.dist_y = dsy;
			expected_q.push_back(r);
		endfunction

		function void note_request(kind_t k, int x, int y);
			int ax, ay, c, fdx, fdy;
			logic nt;
			nt = 1'b0;
			if (!en) begin
				emit(PH_FAILED, 1'b0);
				return;
			end
			if (k != K_START && (ph == PH_FAILED || ph == PH_INTERRUPTED)) begin
				emit(ph, 1'b0);
				return;
			end
			case (k)
				K_START: begin
					hcount = 0;
					ph = PH_UNSURE;
					bx = x; by = y;
					lx = x; ly = y;
				end
				K_NONE: ph = PH_FAILED;
				default: begin
					dx = x - lx;
					dy = y - ly;
					lx = x;
					ly = y;
					if (ph == PH_UNSURE) begin
						if (mag(bx - x) > int'(thr) || mag(by - y) > int'(thr)) begin
							ax = mag(dx);
							ay = mag(dy);
							if (axis == AXIS_ANY || (axis == AXIS_HORZ && ax > ay) ||
									(axis == AXIS_VERT && ax < ay))
								ph = PH_START;
						end
					end else begin
						ph = (k == K_STAY) ? PH_STAY : PH_END;
					end
					if (ph == PH_END) begin
						c = hcount;
						fdx = 0;
						fdy = 0;
						if (c > 0) begin
							fdx = hx[c-1] - hx[0];
							fdy = hy[c-1] - hy[0];
						end
						fling(fdx, c, tmx, dsx);
						fling(fdy, c, tmy, dsy);
					end
					nt = (ph == PH_START || ph == PH_STAY || ph == PH_END);
				end
			endcase
			for (int i = HIST - 1; i > 0; i--) begin
				hx[i] = hx[i-1];
				hy[i] = hy[i-1];
			end
			hx[0] = lx;
			hy[0] = ly;
			if (hcount < HIST)
				hcount++;
			emit(ph, nt);
		endfunction

		function void cmp(string name, logic signed [63:0] e, logic signed [63:0] a);
			if (e !== a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(gesture_result_t a);
			gesture_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp("gesture_state", e.state, a.state);
			cmp("notify", e.notify, a.notify);
			cmp("pos_x", e.pos_x, a.pos_x);
			cmp("pos_y", e.pos_y, a.pos_y);
			cmp("move_dx", e.move_dx, a.move_dx);
			cmp("move_dy", e.move_dy, a.move_dy);
			cmp("origin_x", e.origin_x, a.origin_x);
			cmp("origin_y", e.origin_y, a.origin_y);
			cmp("fling_time_x", e.time_x, a.time_x);
			cmp("fling_time_y", e.time_y, a.time_y);
			cmp("fling_dist_x", e.dist_x, a.dist_x);
			cmp("fling_dist_y", e.dist_y, a.dist_y);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               kind;
	logic [CB-1:0]            touch_x;
	logic [CB-1:0]            touch_y;
	logic                     out_valid;
	logic                     out_ready;
	logic [2:0]               gesture_state;
	logic                     notify;
	logic [CB-1:0]            pos_x;
	logic [CB-1:0]            pos_y;
	logic signed [CB:0]       move_dx;
	logic signed [CB:0]       move_dy;
	logic [CB-1:0]            origin_x;
	logic [CB-1:0]            origin_y;
	logic [TIME_W-1:0]        fling_time_x;
	logic [TIME_W-1:0]        fling_time_y;
	logic signed [DIST_W-1:0] fling_dist_x;
	logic signed [DIST_W-1:0] fling_dist_y;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;

	gesture_scoreboard sb;
	gesture_result_t   seen;
	bit                idle_on;
	bit                hold_long;
	int                items_sent;
	int                cycles;

	pan_gesture_recognizer_unit uut (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			sb.note_request(kind_t'(kind), touch_x, touch_y);

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) begin
			seen.state = phase_t'(gesture_state);
			seen.notify = notify;
			seen.pos_x = pos_x;
			seen.pos_y = pos_y;
			seen.move_dx = move_dx;
			seen.move_dy = move_dy;
			seen.origin_x = origin_x;
			seen.origin_y = origin_y;
			seen.time_x = fling_time_x;
			seen.time_y = fling_time_y;
			seen.dist_x = fling_dist_x;
			seen.dist_y = fling_dist_y;
			sb.check_result(seen);
		end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_long) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_long = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
		end
	end

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	// called and returns at a falling edge; valid stays up after acceptance
	task automatic send_request(kind_t k, int x, int y);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		touch_x <= x[CB-1:0];
		touch_y <= y[CB-1:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apply_settings(logic en, logic [1:0] ax, int th, int rt, int dc);
		logic [CFG_IDX_W-1:0]  idx[5];
		logic [CFG_DATA_W-1:0] vals[5];
		idx = '{REG_ENABLE, REG_AXIS_MODE, REG_THRESHOLD, REG_RATE, REG_DECEL};
		vals = '{CFG_DATA_W'(en), CFG_DATA_W'(ax), CFG_DATA_W'(th), CFG_DATA_W'(rt),
			CFG_DATA_W'(dc)};
		wait_idle();
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			sb.write_reg(idx[i], vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_gesture();
		int x, y, n, sx, sy, big;
		bit horiz;
		if ($urandom_range(0, 5) == 0) begin
			send_request(kind_t'($urandom_range(0, 3)), $urandom_range(0, COORD_MAX),
				$urandom_range(0, COORD_MAX));
			return;
		end
		x = ($urandom_range(0, 7) == 0) ? COORD_MAX * $urandom_range(0, 1)
			: $urandom_range(0, COORD_MAX);
		y = ($urandom_range(0, 7) == 0) ? COORD_MAX * $urandom_range(0, 1)
			: $urandom_range(0, COORD_MAX);
		horiz = 1'($urandom_range(0, 1));
		n = $urandom_range(0, 8);
		send_request(K_START, x, y);
		repeat (n) begin
			big = ($urandom_range(0, 3) == 0) ? 900 : 25;
			sx = int'($urandom_range(0, 2 * big)) - big;
			sy = int'($urandom_range(0, 2 * big)) - big;
			if ($urandom_range(0, 1)) begin
				if (horiz)
					sy = sy / 8;
				else
					sx = sx / 8;
			end
			x = clamp_coord(x + sx);
			y = clamp_coord(y + sy);
			if ($urandom_range(0, 24) == 0)
				send_request(K_NONE, x, y);
			else
				send_request(K_STAY, x, y);
		end
		if ($urandom_range(0, 7) != 0)
			send_request(K_END, clamp_coord(x + int'($urandom_range(0, 60)) - 30),
				clamp_coord(y + int'($urandom_range(0, 60)) - 30));
	endtask

	task automatic run_gestures(int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal)
			random_gesture();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = K_START;
		touch_x = '0;
		touch_y = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		idle_on = 1'b1;
		hold_long = 1'b0;
		items_sent = 0;
		cycles = 0;
		sb = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: full-range pan and fling, failed phase, threshold edge,
		// end without a pan
		send_request(K_START, 0, 0);
		send_request(K_STAY, COORD_MAX, COORD_MAX);
		send_request(K_STAY, COORD_MAX, 0);
		send_request(K_STAY, 0, COORD_MAX);
		send_request(K_END, 0, 0);
		send_request(K_NONE, COORD_MAX, COORD_MAX);
		send_request(K_STAY, 1, 1);
		send_request(K_END, 2, 2);
		send_request(K_START, 100, 100);
		send_request(K_STAY, 110, 100);
		send_request(K_STAY, 111, 100);
		send_request(K_END, 120, 90);
		send_request(K_START, 2048, 2048);
		send_request(K_END, 2050, 2049);

		// horizontal, zero threshold, saturating fling
		apply_settings(1'b1, AXIS_HORZ, 0, 255, 1);
		send_request(K_START, 0, 0);
		send_request(K_STAY, 2000, 0);
		send_request(K_STAY, COORD_MAX, 10);
		send_request(K_END, COORD_MAX, COORD_MAX);
		send_request(K_START, 500, 500);
		send_request(K_STAY, 520, 520);
		send_request(K_STAY, 560, 530);
		run_gestures(60);

		// vertical, top threshold, slowest rate, top deceleration
		apply_settings(1'b1, AXIS_VERT, 255, 1, 65535);
		send_request(K_START, 1000, 1000);
		send_request(K_STAY, 1000, 1255);
		send_request(K_STAY, 1001, 1300);
		send_request(K_END, 1001, 2500);
		run_gestures(60);

		// unused axis mode never pans; zero rate and deceleration
		apply_settings(1'b1, AXIS_UNUSED, 5, 0, 0);
		send_request(K_START, 0, 0);
		send_request(K_STAY, COORD_MAX, COORD_MAX);
		send_request(K_END, 0, COORD_MAX);
		run_gestures(40);

		// zero deceleration with one still axis
		apply_settings(1'b1, AXIS_ANY, 20, 60, 0);
		send_request(K_START, 300, 0);
		send_request(K_STAY, 300, 4000);
		send_request(K_STAY, 300, 100);
		send_request(K_END, 300, 50);
		run_gestures(40);

		apply_settings(1'b0, AXIS_ANY, 10, 60, 5000);
		run_gestures(20);

		for (int p = 0; p < 3; p++) begin
			apply_settings(1'b1, 2'($urandom_range(0, 3)), $urandom_range(0, 255),
				$urandom_range(1, 255),
				$urandom_range(0, 1) ? $urandom_range(1, 400) : $urandom_range(1, 65535));
			if (p == 1)
				hold_long = 1'b1;
			run_gestures(80);
		end

		apply_settings(1'b1, AXIS_ANY, 10, 120, 3000);
		run_gestures(60);
		idle_on = 1'b0;
		run_gestures(60);

		wait_idle();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
